// ===== hdl/sfct_pkg.sv =====
// Shared types, codes and lookup functions for the six-frame codon translator.
package sfct_pkg;

	// Base codes: four nucleotides, one ambiguity code, one error code.
	typedef logic [2:0] base_code_t;
	localparam base_code_t CODE_T       = 3'd0;
	localparam base_code_t CODE_C       = 3'd1;
	localparam base_code_t CODE_A       = 3'd2;
	localparam base_code_t CODE_G       = 3'd3;
	localparam base_code_t CODE_AMBIG   = 3'd4;
	localparam base_code_t CODE_UNKNOWN = 3'd5;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_UNKNOWN = 2'd1;
	localparam status_t ST_SHORT   = 2'd2;
	localparam status_t ST_LONG    = 2'd3;

	typedef logic [6:0] residue_t;
	localparam residue_t RES_AMBIG = 7'h58;	// ASCII 'X'

	// Standard genetic code, indexed by first*16 + second*4 + third with T,C,A,G order.
	localparam logic [64*8-1:0] AMINO_STR =
		"FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

	// One word moved from the input register into the translation stage.
	typedef struct packed {
		logic       step;
		base_code_t code;
		logic       last;
	} item_t;

	// One result word as held in the output register.
	typedef struct packed {
		logic        emitted;
		residue_t    fwd;
		residue_t    rev;
		logic [1:0]  frame;
		logic [14:0] cidx;
		status_t     status;
		logic [15:0] errpos;
		logic        done;
	} result_t;

	// The first character of the string sits in the top byte, so entry i starts at 8*(63-i).
	function automatic residue_t amino_lookup(input logic [5:0] idx);
		logic [8:0] bit_pos;
		bit_pos = {~idx, 3'b000};
		return AMINO_STR[bit_pos +: 7];
	endfunction

	function automatic base_code_t complement(input base_code_t c);
		return (c > CODE_G) ? CODE_AMBIG : (c ^ 3'b010);
	endfunction

	function automatic residue_t codon_residue(input base_code_t p, input base_code_t q,
		input base_code_t r);
		residue_t res;
		if (p > CODE_G || q > CODE_G || r > CODE_G) begin
			res = RES_AMBIG;
		end else begin
			res = amino_lookup({p[1:0], q[1:0], r[1:0]});
		end
		return res;
	endfunction

endpackage

// ===== hdl/sfct_decoder.sv =====
// Folds an ASCII letter to lower case and maps it to a nucleotide base code.
module sfct_decoder (
	input  logic [7:0]          base_char,
	output sfct_pkg::base_code_t code
);
	import sfct_pkg::*;

	logic [7:0] folded;

	always_comb begin
		// Only letters fold; other bytes pass as they are.
		if (base_char inside {["A":"Z"]}) begin
			folded = base_char | 8'h20;
		end else begin
			folded = base_char;
		end
		case (folded) inside
			"t": code = CODE_T;
			"c": code = CODE_C;
			"a": code = CODE_A;
			"g": code = CODE_G;
			"m", "r", "w", "s", "y", "k", "v", "h", "d", "b", "n", "x": code = CODE_AMBIG;
			default: code = CODE_UNKNOWN;
		endcase
	end

endmodule

// ===== hdl/sfct_translate.sv =====
// Sequence state, codon translation and the result register.
module sfct_translate #(
	parameter int MAX_LENGTH = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfct_pkg::item_t   item,
	input  logic              out_ready,
	output logic              out_valid,
	output sfct_pkg::result_t result
);
	import sfct_pkg::*;

	localparam int CW = $clog2(MAX_LENGTH + 1);

	base_code_t  older_q;
	base_code_t  newer_q;
	logic [CW-1:0] count_q;
	logic [1:0]  frame_q;
	logic [14:0] codon_q;
	logic        err_q;

	result_t       res_d;
	base_code_t    older_d;
	base_code_t    newer_d;
	logic [CW-1:0] count_d;
	logic [1:0]    frame_d;
	logic [14:0]   codon_d;
	logic          err_d;

	always_comb begin
		res_d        = '0;
		res_d.done   = item.last;
		older_d      = older_q;
		newer_d      = newer_q;
		count_d      = count_q;
		frame_d      = frame_q;
		codon_d      = codon_q;
		err_d        = err_q;
		if (!err_q) begin
			if (count_q == CW'(MAX_LENGTH)) begin
				res_d.status = ST_LONG;
				err_d        = 1'b1;
			end else if (item.code == CODE_UNKNOWN) begin
				res_d.status = ST_UNKNOWN;
				res_d.errpos = 16'(count_q);
				err_d        = 1'b1;
			end else begin
				if (count_q >= CW'(2)) begin
					res_d.emitted = 1'b1;
					res_d.fwd     = codon_residue(older_q, newer_q, item.code);
					res_d.rev     = codon_residue(complement(item.code),
						complement(newer_q), complement(older_q));
					res_d.frame   = frame_q;
					res_d.cidx    = codon_q;
					if (frame_q == 2'd2) begin
						frame_d = 2'd0;
						codon_d = codon_q + 15'd1;
					end else begin
						frame_d = frame_q + 2'd1;
					end
				end
				older_d = newer_q;
				newer_d = item.code;
				count_d = CW'(count_q + 1'b1);
				if (item.last && count_q < CW'(2)) begin
					res_d.status = ST_SHORT;
				end
			end
		end
		// The end of a sequence returns every piece of state to its reset value.
		if (item.last) begin
			older_d = CODE_T;
			newer_d = CODE_T;
			count_d = '0;
			frame_d = '0;
			codon_d = '0;
			err_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q   <= CODE_T;
			newer_q   <= CODE_T;
			count_q   <= '0;
			frame_q   <= '0;
			codon_q   <= '0;
			err_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (item.step) begin
				older_q   <= older_d;
				newer_q   <= newer_d;
				count_q   <= count_d;
				frame_q   <= frame_d;
				codon_q   <= codon_d;
				err_q     <= err_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.step) begin
			result <= res_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item.step && item.last |=> !err_q && count_q == '0 && frame_q == 2'd0)
		else $error("sequence state not cleared after final word");

	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result.emitted |-> result.status == ST_OK)
		else $error("emitted residue carries an error status");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q != 2'd3)
		else $error("frame counter out of range");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item.step && err_q |=> !result.emitted && result.status == ST_OK)
		else $error("word after a latched error produced output");

endmodule

// ===== hdl/six_frame_codon_translator_unit.sv =====
// Top level of the six-frame codon translator: input register, decoder, translation stage.
// An accepted word waits in the input register and moves to the result register once that is free.
// Throughput: one base word per cycle, held back only when the result register is full and its word is not taken.
// The result register frees as its word is taken, so input and output move in the same cycle.
// Reset (arst_n low, asynchronous) empties both registers and clears all sequence state.
module six_frame_codon_translator_unit #(
	parameter int MAX_LENGTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,	// [7:0] base_char
	input  logic        s_axis_tlast,	// end_of_sequence
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] emitted, [7:1] forward_residue, [14:8] reverse_residue,
	// [16:15] frame_number, [31:17] codon_index, [47:32] error_position
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,	// [1:0] status
	output logic        m_axis_tlast	// sequence_done
);
	import sfct_pkg::*;

	// Input register: one base word waiting for the translation stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	logic       step;
	base_code_t code;
	item_t      item;
	result_t    result;

	// The translation stage consumes a word when the result register is empty or draining.
	assign step          = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	sfct_decoder u_decoder (
		.base_char (char_s1),
		.code      (code)
	);

	assign item.step = step;
	assign item.code = code;
	assign item.last = last_s1;

	sfct_translate #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_translate (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.result    (result)
	);

	// Pack the result word, first field in the lowest bits.
	assign m_axis_tdata = {result.errpos, result.cidx, result.frame,
		result.rev, result.fwd, result.emitted};
	assign m_axis_tuser = result.status;
	assign m_axis_tlast = result.done;

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("input register lost a stalled word");

	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_axis_tvalid)
		else $error("consumed word did not reach the result register");

endmodule
